// ===== hw/rtl/fla_pkg.sv =====
// Shared constants, codes and control/status structs for the free-list ID allocator.
// No dependencies; every allocator module imports this package.
package fla_pkg;

   localparam int MAX_IDS = 256;
   localparam int ID_W    = 8;
   localparam int CNT_W   = 9;

   localparam logic [1:0] REQ_ALLOC  = 2'd0;
   localparam logic [1:0] REQ_RETIRE = 2'd1;
   localparam logic [1:0] REQ_CHECK  = 2'd2;
   localparam logic [1:0] REQ_CLEAR  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NONE    = 2'd1;
   localparam logic [1:0] ST_ALREADY = 2'd2;
   localparam logic [1:0] ST_RANGE   = 2'd3;

   typedef struct packed {
      logic load;
      logic exec;
      logic sweep_start;
      logic sweep;
      logic sweep_finish;
      logic respond;
   } ctrl_cmd_type;

   typedef struct packed {
      logic sweep_last;
   } dp_status_type;

endpackage

// ===== hw/rtl/fla_ctrl.sv =====
// Controller state machine for the free-list ID allocator.
// Depends on fla_pkg; drives the datapath through ctrl_cmd_type.
module fla_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            req_type,
   output logic                  busy,
   output fla_pkg::ctrl_cmd_type cmd,
   input  fla_pkg::dp_status_type status
);
   import fla_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EXEC  = 2'd1;
   localparam logic [1:0] S_CLEAR = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       pend_ff, pend_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      pend_in  = pend_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (req_type == REQ_CLEAR) begin
                  cmd.sweep_start = 1'b1;
                  pend_in         = 1'b1;
                  state_in        = S_CLEAR;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_IDLE;
         end
         S_CLEAR: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               // The pass after reset refills silently; a requested clear answers.
               cmd.sweep_finish = 1'b1;
               cmd.respond      = pend_ff;
               pend_in          = 1'b0;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== hw/rtl/fla_datapath.sv =====
// Datapath of the free-list ID allocator: id_count register, free queue and free
// bitmap memories, pointers, counters and response registers. Depends on fla_pkg.
module fla_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  fla_pkg::ctrl_cmd_type      cmd,
   output fla_pkg::dp_status_type     status,
   input  logic [1:0]                 req_type,
   input  logic [fla_pkg::ID_W-1:0]   req_id_value,
   input  logic                       csr_we,
   input  logic [fla_pkg::CNT_W-1:0]  csr_id_count,
   output logic                       rsp_valid,
   output logic [fla_pkg::ID_W-1:0]   rsp_out_id,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_is_free,
   output logic [fla_pkg::CNT_W-1:0]  rsp_in_use_count
);
   import fla_pkg::*;

   logic [ID_W-1:0]  queue_mem [MAX_IDS];
   logic             map_mem   [MAX_IDS];

   logic [CNT_W-1:0] id_count_ff;
   logic [CNT_W-1:0] eff_n;

   logic [ID_W-1:0]  head_ff, head_in, tail_ff, tail_in, cnt_ff, cnt_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [1:0]       op_ff, op_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic             range_ff, range_in;
   logic [ID_W-1:0]  q_rd_ff;
   logic             m_rd_ff;

   logic             q_we, m_we, m_data;
   logic [ID_W-1:0]  q_addr, q_data, m_addr;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]  rsp_id_ff, rsp_id_in;
   logic [1:0]       rsp_st_ff, rsp_st_in;
   logic             rsp_free_ff, rsp_free_in;
   logic [CNT_W-1:0] rsp_act_ff, rsp_act_in;

   // Counts above the queue depth behave as the full depth.
   assign eff_n = (id_count_ff > CNT_W'(MAX_IDS)) ? CNT_W'(MAX_IDS) : id_count_ff;
   assign status.sweep_last = (cnt_ff == ID_W'(MAX_IDS - 1));

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      total_in     = total_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      range_in     = range_ff;
      q_we         = 1'b0;
      q_addr       = tail_ff;
      q_data       = id_ff;
      m_we         = 1'b0;
      m_addr       = id_ff;
      m_data       = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_id_in    = '0;
      rsp_st_in    = ST_OK;
      rsp_free_in  = 1'b0;

      if (cmd.load) begin
         op_in    = req_type;
         id_in    = req_id_value;
         range_in = ({1'b0, req_id_value} < eff_n);
      end
      if (cmd.sweep_start) begin
         cnt_in = '0;
      end
      if (cmd.sweep) begin
         q_we   = 1'b1;
         q_addr = cnt_ff;
         q_data = cnt_ff;
         m_we   = 1'b1;
         m_addr = cnt_ff;
         m_data = ({1'b0, cnt_ff} < eff_n);
         cnt_in = cnt_ff + ID_W'(1);
      end
      if (cmd.sweep_finish) begin
         head_in      = '0;
         tail_in      = eff_n[ID_W-1:0];
         total_in     = eff_n;
         rsp_valid_in = cmd.respond;
      end
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
         case (op_ff)
            REQ_ALLOC: begin
               if (total_ff == '0) begin
                  rsp_st_in = ST_NONE;
               end else begin
                  rsp_id_in = q_rd_ff;
                  m_we      = 1'b1;
                  m_addr    = q_rd_ff;
                  m_data    = 1'b0;
                  head_in   = head_ff + ID_W'(1);
                  total_in  = total_ff - CNT_W'(1);
               end
            end
            REQ_RETIRE: begin
               if (!range_ff) begin
                  rsp_st_in = ST_RANGE;
               end else if (m_rd_ff) begin
                  rsp_st_in = ST_ALREADY;
               end else begin
                  q_we     = 1'b1;
                  m_we     = 1'b1;
                  m_data   = 1'b1;
                  tail_in  = tail_ff + ID_W'(1);
                  total_in = total_ff + CNT_W'(1);
               end
            end
            REQ_CHECK: begin
               if (!range_ff) begin
                  rsp_st_in = ST_RANGE;
               end else begin
                  rsp_free_in = m_rd_ff;
               end
            end
            default: begin
               rsp_st_in = ST_OK;
            end
         endcase
      end
      rsp_act_in = (eff_n > total_in) ? (eff_n - total_in) : '0;
   end

   // Both memories read once per transaction, at acceptance; writes happen only
   // in the execute and sweep cycles, so a read never meets a write.
   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_mem[q_addr] <= q_data;
      end
      if (cmd.load) begin
         q_rd_ff <= queue_mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (m_we) begin
         map_mem[m_addr] <= m_data;
      end
      if (cmd.load) begin
         m_rd_ff <= map_mem[req_id_value];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_count_ff  <= CNT_W'(MAX_IDS);
         head_ff      <= '0;
         tail_ff      <= '0;
         total_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            id_count_ff <= csr_id_count;
         end
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         total_ff     <= total_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      id_ff       <= id_in;
      range_ff    <= range_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_free_ff <= rsp_free_in;
      rsp_act_ff  <= rsp_act_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_id       = rsp_id_ff;
   assign rsp_status       = rsp_st_ff;
   assign rsp_is_free      = rsp_free_ff;
   assign rsp_in_use_count = rsp_act_ff;

   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response strobe held for two cycles");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(MAX_IDS))
      else $error("free count exceeds queue depth");

   a_alloc_pop: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && op_ff == REQ_ALLOC && total_ff != '0)
      |=> (total_ff == $past(total_ff) - CNT_W'(1)) && rsp_st_ff == ST_OK)
      else $error("successful allocate did not pop one entry");

   a_sweep_map: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> !cmd.sweep)
      else $error("execute and sweep share the memory write ports");

endmodule

// ===== hw/rtl/free_list_id_allocator_core.sv =====
// Free-list ID allocator: a FIFO of free IDs with a free bitmap, one controller
// and one datapath. Depends on fla_pkg, fla_ctrl and fla_datapath.
//
// A transaction is accepted when start is high and busy is low. For allocate,
// retire and check, the edge that accepts reads the queue head and the bitmap
// entry, the next edge makes any memory update and registers the response, and
// rsp_valid is high for exactly one cycle after that; a new transaction may be
// accepted in that same cycle, but not before the previous one has responded.
// Clear and refill sweeps all 256 queue and bitmap entries, one per cycle over the
// single write port of each memory; its response is registered on the edge that
// writes the last entry, and the next transaction may be accepted in that response
// cycle. After reset the same clearing pass runs with busy high and produces no
// response. Responses cannot be stalled; the receiver must take each one in the
// cycle it is shown. csr_id_count may be written only while the block is idle.
module free_list_id_allocator_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_type,
   input  logic [fla_pkg::ID_W-1:0]  req_id_value,
   input  logic                      csr_we,
   input  logic [fla_pkg::CNT_W-1:0] csr_id_count,
   output logic                      rsp_valid,
   output logic [fla_pkg::ID_W-1:0]  rsp_out_id,
   output logic [1:0]                rsp_status,
   output logic                      rsp_is_free,
   output logic [fla_pkg::CNT_W-1:0] rsp_in_use_count
);
   import fla_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   fla_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .busy     (busy),
      .cmd      (cmd),
      .status   (status)
   );

   fla_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_type         (req_type),
      .req_id_value     (req_id_value),
      .csr_we           (csr_we),
      .csr_id_count     (csr_id_count),
      .rsp_valid        (rsp_valid),
      .rsp_out_id       (rsp_out_id),
      .rsp_status       (rsp_status),
      .rsp_is_free      (rsp_is_free),
      .rsp_in_use_count (rsp_in_use_count)
   );

endmodule
